// ===== hdl/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types, constants and helpers for the motion sleep classifier.
// ----------------------------------------------------------------------------
package msc_pkg;

    // Default number of early-morning hours with a wear count
    localparam int WEAR_HOURS_DEF = 6;

    // Field widths
    localparam int MAG_W   = 17;
    localparam int CNT16_W = 16;
    localparam int HOUR_W  = 5;
    localparam int PHASE_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Time-of-day and timing constants
    localparam logic [HOUR_W-1:0]  NIGHT_START  = 5'd20;
    localparam logic [HOUR_W-1:0]  NIGHT_END    = 5'd8;
    localparam logic [PHASE_W-1:0] MINUTE_LAST  = 6'd59;
    localparam logic [2:0]         UNWORN_LIMIT = 3'd7;
    localparam logic [CNT16_W-1:0] MAX16        = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAR_THRESHOLD       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_SECONDS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEEP_STILL_SECONDS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNWORN_STILL_SECONDS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEDENTARY_LIMIT      = 3'd5;

    // Configuration reset values
    localparam logic [MAG_W-1:0]   RST_MOTION_THRESHOLD     = 17'd120;
    localparam logic [MAG_W-1:0]   RST_WEAR_THRESHOLD       = 17'd200;
    localparam logic [CNT16_W-1:0] RST_QUIET_SECONDS        = 16'd60;
    localparam logic [CNT16_W-1:0] RST_DEEP_STILL_SECONDS   = 16'd600;
    localparam logic [CNT16_W-1:0] RST_UNWORN_STILL_SECONDS = 16'd7200;
    localparam logic [CNT16_W-1:0] RST_SEDENTARY_LIMIT      = 16'd180;

    // Input item
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [15:0]        step_total;
        logic [7:0]         heart_rate;
        logic [4:0]         hour_of_day;
        logic               is_charging;
        logic               worn_now;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [15:0] deep_total;
        logic [15:0] light_total;
        logic        minute_record;
    } t_out_item;

    // Item after the magnitude stage
    typedef struct packed {
        logic [MAG_W-1:0]   magnitude;
        logic [15:0]        step_total;
        logic [7:0]         heart_rate;
        logic [HOUR_W-1:0]  hour_of_day;
        logic               is_charging;
        logic               worn_now;
    } t_stage_item;

    // Configuration register set
    typedef struct packed {
        logic [MAG_W-1:0]   motion_threshold;
        logic [MAG_W-1:0]   wear_threshold;
        logic [CNT16_W-1:0] quiet_seconds;
        logic [CNT16_W-1:0] deep_still_seconds;
        logic [CNT16_W-1:0] unworn_still_seconds;
        logic [CNT16_W-1:0] sedentary_limit;
    } t_cfg;

    // Saturating 16-bit increment
    function automatic logic [CNT16_W-1:0] sat_inc16(input logic [CNT16_W-1:0] v);
        return (v == MAX16) ? MAX16 : v + 16'd1;
    endfunction

endpackage

// ===== hdl/motion_sleep_classifier_core.sv =====
// ----------------------------------------------------------------------------
// motion_sleep_classifier_core
// Night-time sleep estimator fed with one accelerometer sample per second.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (axes, step count, heart rate, hour, charging, worn) enter on
//   i_in_valid / o_in_ready; one result item (deep and light totals plus a
//   minute flag) leaves on o_out_valid / i_out_ready for every input item.
//   Registers are written through i_cfg_we / i_cfg_index / i_cfg_data while
//   no item is in flight, a rule for the user that the block itself does not
//   enforce; they take effect for the next item.
//   An item is registered in the magnitude stage, then evaluated into the
//   output register. Throughput: one item per cycle unless the receiver
//   stalls; each item's state update is made as it is evaluated.
//   Reset (synchronous, active low) empties both stages, clears all tracking
//   and sleep totals and loads the register defaults.
//   When the receiver stalls, the result holds in the output register, the
//   magnitude stage fills, and o_in_ready drops once both are occupied.
// ----------------------------------------------------------------------------
module motion_sleep_classifier_core
    import msc_pkg::*;
#(
    parameter int WEAR_HOURS = WEAR_HOURS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic        stage_valid;
    logic        stage_ready;
    t_stage_item stage_item;
    logic        fire;
    t_out_item   result;
    logic        r_out_valid;
    t_out_item   r_out_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motion_threshold     <= RST_MOTION_THRESHOLD;
            r_cfg.wear_threshold       <= RST_WEAR_THRESHOLD;
            r_cfg.quiet_seconds        <= RST_QUIET_SECONDS;
            r_cfg.deep_still_seconds   <= RST_DEEP_STILL_SECONDS;
            r_cfg.unworn_still_seconds <= RST_UNWORN_STILL_SECONDS;
            r_cfg.sedentary_limit      <= RST_SEDENTARY_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MOTION_THRESHOLD:     r_cfg.motion_threshold     <= i_cfg_data;
                CFG_WEAR_THRESHOLD:       r_cfg.wear_threshold       <= i_cfg_data;
                CFG_QUIET_SECONDS:        r_cfg.quiet_seconds        <= i_cfg_data[15:0];
                CFG_DEEP_STILL_SECONDS:   r_cfg.deep_still_seconds   <= i_cfg_data[15:0];
                CFG_UNWORN_STILL_SECONDS: r_cfg.unworn_still_seconds <= i_cfg_data[15:0];
                CFG_SEDENTARY_LIMIT:      r_cfg.sedentary_limit      <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Magnitude stage
    msc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_valid    (stage_valid),
        .i_ready    (stage_ready),
        .o_item     (stage_item)
    );

    // Evaluate when the output register can take the result
    assign stage_ready = !r_out_valid || i_out_ready;
    assign fire        = stage_valid && stage_ready;

    msc_eval #(
        .WEAR_HOURS (WEAR_HOURS)
    ) u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Output register: hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_ready) begin
            r_out_valid <= stage_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== hdl/msc_front.sv =====
// ----------------------------------------------------------------------------
// msc_front
// Input stage: takes an item and registers it with its motion magnitude.
// ----------------------------------------------------------------------------
module msc_front
    import msc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_stage_item o_item
);

    logic        r_valid;
    t_stage_item r_item;
    t_stage_item n_item;
    logic signed [17:0] sum;
    logic signed [17:0] neg_sum;

    // Accept when empty or when the held item moves on
    assign o_in_ready = !r_valid || i_ready;

    // Magnitude of the axis sum
    always_comb begin
        sum     = 18'(i_in_item.accel_x) + 18'(i_in_item.accel_y) + 18'(i_in_item.accel_z);
        neg_sum = -sum;
        n_item.magnitude   = sum[17] ? neg_sum[MAG_W-1:0] : sum[MAG_W-1:0];
        n_item.step_total  = i_in_item.step_total;
        n_item.heart_rate  = i_in_item.heart_rate;
        n_item.hour_of_day = i_in_item.hour_of_day;
        n_item.is_charging = i_in_item.is_charging;
        n_item.worn_now    = i_in_item.worn_now;
    end

    // Hold valid until the item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hdl/msc_eval.sv =====
// ----------------------------------------------------------------------------
// msc_eval
// Tracking state and minute evaluation; produces one result per item.
// ----------------------------------------------------------------------------
module msc_eval
    import msc_pkg::*;
#(
    parameter int WEAR_HOURS = WEAR_HOURS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_stage_item i_item,
    input  t_cfg        i_cfg,
    output t_out_item   o_result
);

    // State registers
    logic [MAG_W-1:0]   r_prev_mag;
    logic [15:0]        r_prev_steps;
    logic [PHASE_W-1:0] r_phase;
    logic               r_hold;
    logic [15:0]        r_still;
    logic [2:0]         r_unworn;
    logic [15:0]        r_active;
    logic [15:0]        r_wear [WEAR_HOURS];
    logic [15:0]        r_light;
    logic [15:0]        r_deep;
    logic [15:0]        r_rep_light;
    logic [15:0]        r_rep_deep;

    // Next values
    logic [MAG_W-1:0]   n_prev_mag;
    logic [15:0]        n_prev_steps;
    logic [PHASE_W-1:0] n_phase;
    logic               n_hold;
    logic [15:0]        n_still;
    logic [2:0]         n_unworn;
    logic [15:0]        n_active;
    logic [15:0]        n_wear [WEAR_HOURS];
    logic [15:0]        n_light;
    logic [15:0]        n_deep;
    logic [15:0]        n_rep_light;
    logic [15:0]        n_rep_deep;
    logic               n_record;

    logic [MAG_W:0]     mag_delta;
    logic [MAG_W:0]     mag_delta_neg;
    logic [MAG_W-1:0]   diff;
    logic               wear_hit;
    logic               stepped;
    logic               early;
    logic               night;
    logic [3:0]         zero_cnt;

    always_comb begin
        n_prev_mag   = r_prev_mag;
        n_prev_steps = r_prev_steps;
        n_phase      = r_phase;
        n_hold       = r_hold;
        n_still      = r_still;
        n_unworn     = r_unworn;
        n_active     = r_active;
        n_light      = r_light;
        n_deep       = r_deep;
        n_rep_light  = r_rep_light;
        n_rep_deep   = r_rep_deep;
        n_record     = 1'b0;
        for (int i = 0; i < WEAR_HOURS; i++) begin
            n_wear[i] = r_wear[i];
        end

        // Magnitude change since the previous sample
        mag_delta     = {1'b0, r_prev_mag} - {1'b0, i_item.magnitude};
        mag_delta_neg = -mag_delta;
        diff          = mag_delta[MAG_W] ? mag_delta_neg[MAG_W-1:0] : mag_delta[MAG_W-1:0];

        wear_hit = ((diff >= i_cfg.wear_threshold) || (i_item.heart_rate != 8'd0)) &&
                   (i_item.hour_of_day < HOUR_W'(WEAR_HOURS));
        stepped  = (r_prev_steps < i_item.step_total) && (r_prev_steps != 16'd0);
        early    = i_item.hour_of_day < NIGHT_END;
        night    = (i_item.hour_of_day >= NIGHT_START) || early;
        zero_cnt = 4'd0;

        if (!i_item.is_charging) begin
            // Stillness tracking
            n_still = (diff >= i_cfg.motion_threshold) ? 16'd0 : sat_inc16(r_still);

            // Per-hour wear counts
            for (int i = 0; i < WEAR_HOURS; i++) begin
                if (wear_hit && (i_item.hour_of_day == HOUR_W'(i))) begin
                    n_wear[i] = sat_inc16(r_wear[i]);
                end
            end

            n_prev_mag = i_item.magnitude;

            // Minute evaluation
            if (r_phase == '0) begin
                n_record = 1'b1;

                if (stepped || r_hold) begin
                    n_hold = stepped;
                    if (early) begin
                        n_active = sat_inc16(r_active);
                    end
                end else if (n_still <= i_cfg.quiet_seconds) begin
                    n_active = early ? sat_inc16(r_active) : 16'd0;
                end

                if (night) begin
                    // Count unworn hours once per morning
                    if ((i_item.hour_of_day >= HOUR_W'(WEAR_HOURS)) &&
                        (i_item.hour_of_day <= NIGHT_END) && (r_unworn == 3'd0)) begin
                        for (int i = 0; i < WEAR_HOURS; i++) begin
                            zero_cnt = zero_cnt + {3'd0, (n_wear[i] == 16'd0)};
                        end
                        n_unworn = (zero_cnt >= 4'd7) ? UNWORN_LIMIT : zero_cnt[2:0];
                    end

                    if ((n_still >= i_cfg.unworn_still_seconds) ||
                        (n_unworn >= UNWORN_LIMIT) ||
                        (early && (n_active > i_cfg.sedentary_limit))) begin
                        // Drop the night's totals
                        n_active    = 16'd0;
                        n_light     = 16'd0;
                        n_deep      = 16'd0;
                        n_rep_light = 16'd0;
                        n_rep_deep  = 16'd0;
                    end else if ((r_prev_steps == i_item.step_total) &&
                                 (n_still >= i_cfg.quiet_seconds)) begin
                        if (i_item.worn_now) begin
                            if (n_still >= i_cfg.deep_still_seconds) begin
                                n_deep = sat_inc16(r_deep);
                            end else begin
                                n_light = sat_inc16(r_light);
                            end
                        end
                        n_rep_light = n_light;
                        n_rep_deep  = n_deep;
                    end
                end else begin
                    // Daytime: clear tracking, keep reported totals
                    n_prev_mag = '0;
                    n_hold     = 1'b0;
                    n_still    = 16'd0;
                    n_unworn   = 3'd0;
                    n_light    = 16'd0;
                    n_deep     = 16'd0;
                    n_active   = 16'd0;
                    for (int i = 0; i < WEAR_HOURS; i++) begin
                        n_wear[i] = 16'd0;
                    end
                end
            end

            // Advance the second counter
            n_phase      = (r_phase == MINUTE_LAST) ? '0 : r_phase + 6'd1;
            n_prev_steps = i_item.step_total;
        end
    end

    // Update state on each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mag   <= '0;
            r_prev_steps <= '0;
            r_phase      <= '0;
            r_hold       <= 1'b0;
            r_still      <= '0;
            r_unworn     <= '0;
            r_active     <= '0;
            r_light      <= '0;
            r_deep       <= '0;
            r_rep_light  <= '0;
            r_rep_deep   <= '0;
            for (int i = 0; i < WEAR_HOURS; i++) begin
                r_wear[i] <= '0;
            end
        end else if (i_fire) begin
            r_prev_mag   <= n_prev_mag;
            r_prev_steps <= n_prev_steps;
            r_phase      <= n_phase;
            r_hold       <= n_hold;
            r_still      <= n_still;
            r_unworn     <= n_unworn;
            r_active     <= n_active;
            r_light      <= n_light;
            r_deep       <= n_deep;
            r_rep_light  <= n_rep_light;
            r_rep_deep   <= n_rep_deep;
            for (int i = 0; i < WEAR_HOURS; i++) begin
                r_wear[i] <= n_wear[i];
            end
        end
    end

    assign o_result.deep_total    = n_rep_deep;
    assign o_result.light_total   = n_rep_light;
    assign o_result.minute_record = n_record;

`ifndef SYNTHESIS
    // A minute evaluation only runs at the start of a minute
    a_record_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.minute_record) |-> (r_phase == '0))
        else $error("minute record outside phase zero");

    // The second counter stays within one minute
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= MINUTE_LAST)
        else $error("second phase out of range");

    // A charging item leaves the tracking state alone
    a_charging_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.is_charging) |=>
            ($stable(r_still) && $stable(r_phase) && $stable(r_rep_deep)))
        else $error("state changed while charging");

    // Reported totals only move with an item
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_rep_light) && $stable(r_rep_deep)))
        else $error("reported totals changed without an item");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motion sleep classifier core. Night-like
// sample streams with random content are driven through the valid/ready
// input and checked against a cycle-free model of the sleep totals, across
// default, tight, all-zero, all-ones and random register settings.
// ----------------------------------------------------------------------------
module tb;
    import msc_pkg::*;

    localparam int WEAR_HOURS  = WEAR_HOURS_DEF;
    localparam int CYCLE_LIMIT = 100000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    motion_sleep_classifier_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Stimulus and scoreboard storage
    t_in_item  sample_queue[$];
    t_out_item expected_totals[$];
    logic      in_taken   = 1'b0;
    int        idle_pct   = 9;
    int        mismatches = 0;

    // Model copy of the registers and tracking state
    t_cfg                 cfg_now;
    logic [MAG_W-1:0]     prev_mag;
    logic [15:0]          prev_steps;
    logic [PHASE_W-1:0]   sec_phase;
    logic                 hold;
    logic [15:0]          still_secs;
    logic [2:0]           unworn_hrs;
    logic [15:0]          active_mins;
    logic [15:0]          wear_count[WEAR_HOURS];
    logic [15:0]          light_mins;
    logic [15:0]          deep_mins;
    logic [15:0]          rep_light;
    logic [15:0]          rep_deep;

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == MAX16) ? v : v + 16'd1;
    endfunction

    // Advance the model by one sample and return the totals it reports
    function automatic t_out_item predict_totals(input t_in_item s);
        int        sum;
        int        mag;
        int        d;
        int        k;
        int        diff;
        logic      stepped;
        t_out_item r;
        r.minute_record = 1'b0;
        if (!s.is_charging) begin
            sum = int'($signed(s.accel_x)) + int'($signed(s.accel_y)) + int'($signed(s.accel_z));
            mag = (sum < 0) ? -sum : sum;
            d = int'(prev_mag) - mag;
            diff = (d < 0) ? -d : d;

            if (diff >= int'(cfg_now.motion_threshold))
                still_secs = '0;
            else
                still_secs = bump16(still_secs);

            if ((diff >= int'(cfg_now.wear_threshold) || s.heart_rate != 8'd0)
                    && s.hour_of_day < HOUR_W'(WEAR_HOURS))
                wear_count[s.hour_of_day[2:0]] = bump16(wear_count[s.hour_of_day[2:0]]);

            prev_mag = mag[MAG_W-1:0];

            // Minute evaluation on the first second of each minute
            if (sec_phase == '0) begin
                stepped = (prev_steps < s.step_total) && (prev_steps != 16'd0);
                r.minute_record = 1'b1;

                if (stepped || hold) begin
                    hold = stepped;
                    if (s.hour_of_day < NIGHT_END)
                        active_mins = bump16(active_mins);
                end else if (still_secs <= cfg_now.quiet_seconds) begin
                    if (s.hour_of_day < NIGHT_END)
                        active_mins = bump16(active_mins);
                    else
                        active_mins = '0;
                end

                if (s.hour_of_day >= NIGHT_START || s.hour_of_day < NIGHT_END) begin
                    if (s.hour_of_day >= HOUR_W'(WEAR_HOURS) && s.hour_of_day <= NIGHT_END
                            && unworn_hrs == 3'd0) begin
                        for (k = 0; k < WEAR_HOURS; k++)
                            if (wear_count[k] == 16'd0 && unworn_hrs < UNWORN_LIMIT)
                                unworn_hrs = unworn_hrs + 3'd1;
                    end
                    if (still_secs >= cfg_now.unworn_still_seconds
                            || unworn_hrs >= UNWORN_LIMIT
                            || (s.hour_of_day < NIGHT_END
                                && active_mins > cfg_now.sedentary_limit)) begin
                        active_mins = '0;
                        light_mins  = '0;
                        deep_mins   = '0;
                        rep_light   = '0;
                        rep_deep    = '0;
                    end else if (prev_steps == s.step_total
                            && still_secs >= cfg_now.quiet_seconds) begin
                        if (s.worn_now) begin
                            if (still_secs >= cfg_now.deep_still_seconds)
                                deep_mins = bump16(deep_mins);
                            else
                                light_mins = bump16(light_mins);
                        end
                        rep_light = light_mins;
                        rep_deep  = deep_mins;
                    end
                end else begin
                    // Daytime: drop tracking, keep the reported totals
                    prev_mag    = '0;
                    hold        = 1'b0;
                    still_secs  = '0;
                    unworn_hrs  = '0;
                    light_mins  = '0;
                    deep_mins   = '0;
                    active_mins = '0;
                    for (k = 0; k < WEAR_HOURS; k++)
                        wear_count[k] = '0;
                end
            end

            sec_phase  = (sec_phase == MINUTE_LAST) ? '0 : sec_phase + 1'b1;
            prev_steps = s.step_total;
        end
        r.deep_total  = rep_deep;
        r.light_total = rep_light;
        return r;
    endfunction

    function automatic t_in_item mk(input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] z, input logic [15:0] steps,
                                    input logic [7:0] hr, input logic [4:0] hour,
                                    input logic chg, input logic worn);
        t_in_item s;
        s.accel_x     = x;
        s.accel_y     = y;
        s.accel_z     = z;
        s.step_total  = steps;
        s.heart_rate  = hr;
        s.hour_of_day = hour;
        s.is_charging = chg;
        s.worn_now    = worn;
        return s;
    endfunction

    function automatic t_in_item any_sample();
        return mk(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom), 5'($urandom),
                  ($urandom_range(0, 9) == 0), 1'($urandom));
    endfunction

    task automatic queue_noise(input int n);
        repeat (n) sample_queue.push_back(any_sample());
    endtask

    // Queue one night: hour segments in order with a mood each, then a daytime tail
    task automatic queue_night(input int jit, input int max_segs);
        logic [4:0]  hour;
        logic [15:0] bx;
        logic [15:0] by;
        logic [15:0] bz;
        logic [15:0] steps;
        logic [7:0]  pulse;
        logic        on_wrist;
        int          seg;
        int          mood;
        t_in_item    s;
        hour = ($urandom_range(0, 99) < 60) ? 5'($urandom_range(0, 3))
                                            : 5'($urandom_range(20, 31));
        steps = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        bx = 16'($urandom);
        by = 16'($urandom);
        bz = 16'($urandom);
        for (seg = 0; seg < max_segs; seg++) begin
            mood     = $urandom_range(0, 99);
            pulse    = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(40, 255));
            on_wrist = ($urandom_range(0, 9) != 0);
            repeat ($urandom_range(10, 70)) begin
                // restless and active moods jump now and then; active ones walk
                if (mood >= 55 && $urandom_range(0, 9) == 0) begin
                    bx = 16'($urandom);
                    by = 16'($urandom);
                    bz = 16'($urandom);
                end
                if (mood >= 80)
                    steps = steps + 16'($urandom_range(0, 4));
                s = mk(bx + 16'($urandom_range(0, jit)), by + 16'($urandom_range(0, jit)),
                       bz + 16'($urandom_range(0, jit)), steps, pulse, hour,
                       ($urandom_range(0, 49) == 0), on_wrist);
                sample_queue.push_back(s);
            end
            if (hour == NIGHT_END)
                break;
            hour = (hour == 5'd23 || hour == 5'd31) ? 5'd0 : hour + 5'd1;
        end
        hour = 5'($urandom_range(8, 19));
        repeat ($urandom_range(3, 15)) begin
            s = any_sample();
            s.hour_of_day = hour;
            sample_queue.push_back(s);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        case (idx)
            CFG_MOTION_THRESHOLD:     cfg_now.motion_threshold     = val;
            CFG_WEAR_THRESHOLD:       cfg_now.wear_threshold       = val;
            CFG_QUIET_SECONDS:        cfg_now.quiet_seconds        = val[CNT16_W-1:0];
            CFG_DEEP_STILL_SECONDS:   cfg_now.deep_still_seconds   = val[CNT16_W-1:0];
            CFG_UNWORN_STILL_SECONDS: cfg_now.unworn_still_seconds = val[CNT16_W-1:0];
            CFG_SEDENTARY_LIMIT:      cfg_now.sedentary_limit      = val[CNT16_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] motion,
                             input logic [CFG_DATA_W-1:0] wear,
                             input logic [CFG_DATA_W-1:0] quiet,
                             input logic [CFG_DATA_W-1:0] deep,
                             input logic [CFG_DATA_W-1:0] unworn,
                             input logic [CFG_DATA_W-1:0] sedentary);
        write_reg(CFG_MOTION_THRESHOLD, motion);
        write_reg(CFG_WEAR_THRESHOLD, wear);
        write_reg(CFG_QUIET_SECONDS, quiet);
        write_reg(CFG_DEEP_STILL_SECONDS, deep);
        write_reg(CFG_UNWORN_STILL_SECONDS, unworn);
        write_reg(CFG_SEDENTARY_LIMIT, sedentary);
    endtask

    // Hold the sender until every queued item is out and every result is back
    task automatic drain();
        while (sample_queue.size() != 0 || i_in_valid || expected_totals.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Drive input items from the queue, idling at random
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (i_rst_n && sample_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_in_item  <= sample_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Predict on acceptance, compare on each delivered result
    always @(posedge i_clk) begin
        t_out_item want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_totals.push_back(predict_totals(i_in_item));
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_totals.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got %p", $time, o_out_item);
                mismatches++;
            end else begin
                want = expected_totals.pop_front();
                check_field("deep_total", want.deep_total, o_out_item.deep_total);
                check_field("light_total", want.light_total, o_out_item.light_total);
                check_field("minute_record", 16'(want.minute_record),
                            16'(o_out_item.minute_record));
            end
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int k;
        cfg_now.motion_threshold     = RST_MOTION_THRESHOLD;
        cfg_now.wear_threshold       = RST_WEAR_THRESHOLD;
        cfg_now.quiet_seconds        = RST_QUIET_SECONDS;
        cfg_now.deep_still_seconds   = RST_DEEP_STILL_SECONDS;
        cfg_now.unworn_still_seconds = RST_UNWORN_STILL_SECONDS;
        cfg_now.sedentary_limit      = RST_SEDENTARY_LIMIT;
        prev_mag    = '0;
        prev_steps  = '0;
        sec_phase   = '0;
        hold        = 1'b0;
        still_secs  = '0;
        unworn_hrs  = '0;
        active_mins = '0;
        light_mins  = '0;
        deep_mins   = '0;
        rep_light   = '0;
        rep_deep    = '0;
        for (k = 0; k < WEAR_HOURS; k++)
            wear_count[k] = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items at reset settings: field extremes, charging, odd hours
        sample_queue.push_back(mk(16'h8000, 16'h8000, 16'h8000, 16'd0, 8'd0, 5'd0, 1'b0, 1'b0));
        sample_queue.push_back(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 8'hFF, 5'd31,
                                  1'b0, 1'b1));
        sample_queue.push_back(mk(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 8'd0, 5'd24,
                                  1'b0, 1'b1));
        sample_queue.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'd100, 8'd1, 5'd5,
                                  1'b1, 1'b1));
        sample_queue.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'd100, 8'd0, 5'd5,
                                  1'b0, 1'b1));
        sample_queue.push_back(mk(16'h0001, 16'hFFFF, 16'h0000, 16'd100, 8'd0, 5'd6,
                                  1'b0, 1'b0));
        sample_queue.push_back(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd101, 8'd0, 5'd7,
                                  1'b0, 1'b1));
        sample_queue.push_back(mk(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h55, 5'd21,
                                  1'b0, 1'b1));
        sample_queue.push_back(mk(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA, 5'd10,
                                  1'b0, 1'b0));
        sample_queue.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'd101, 8'd0, 5'd8,
                                  1'b0, 1'b1));
        sample_queue.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'd101, 8'd0, 5'd19,
                                  1'b0, 1'b1));
        sample_queue.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'd101, 8'd0, 5'd20,
                                  1'b0, 1'b1));
        sample_queue.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'd101, 8'd0, 5'd23,
                                  1'b0, 1'b1));
        sample_queue.push_back(mk(16'h8000, 16'h7FFF, 16'h0001, 16'd0, 8'd128, 5'd2,
                                  1'b0, 1'b1));
        for (k = 0; k < 8; k++)
            sample_queue.push_back(mk(16'd100, 16'd0, 16'd0, 16'd101, 8'd0, 5'(k),
                                      (k % 3 == 0), 1'b1));
        drain();

        // Tight settings so that sleep, deep sleep and clearing all show up
        write_all(17'd40, 17'd90, 17'd3, 17'd20, 17'd300, 17'd6);
        queue_night(8, 7);
        queue_night(8, 7);
        queue_noise(40);
        drain();
        queue_night(8, 7);
        drain();

        // All registers at zero
        write_all(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
        queue_night(8, 3);
        queue_noise(30);
        drain();

        // All registers at their top value
        write_all(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        queue_night(8, 3);
        queue_noise(30);
        drain();

        // Random settings, no idling on either side
        write_all(17'($urandom_range(0, 300)), 17'($urandom_range(0, 400)),
                  17'($urandom_range(0, 80)), 17'($urandom_range(0, 200)),
                  17'($urandom_range(100, 2000)), 17'($urandom_range(0, 30)));
        idle_pct = 0;
        queue_night(4, 4);
        queue_night(4, 4);
        drain();
        idle_pct = 9;

        // Back to the reset settings
        write_all(RST_MOTION_THRESHOLD, RST_WEAR_THRESHOLD, 17'(RST_QUIET_SECONDS),
                  17'(RST_DEEP_STILL_SECONDS), 17'(RST_UNWORN_STILL_SECONDS),
                  17'(RST_SEDENTARY_LIMIT));
        queue_night(20, 3);
        queue_noise(30);
        drain();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
